@@ design/ean13_pkg.sv @@
`default_nettype none

package ean13_pkg;

    localparam int DigitCount = 12;
    localparam int SumWidth   = 8;

    typedef logic [DigitCount-1:0][3:0] digit_vec_t;
    typedef logic [SumWidth-1:0]        wsum_t;

    // Chunk positions within one run
    typedef logic [3:0] chunk_idx_t;
    localparam chunk_idx_t IDX_START  = 4'd0;
    localparam chunk_idx_t IDX_LEFT_LAST = 4'd6;
    localparam chunk_idx_t IDX_CENTER = 4'd7;
    localparam chunk_idx_t IDX_CHECK  = 4'd13;
    localparam chunk_idx_t IDX_END    = 4'd14;

    // Module counts per chunk kind
    localparam logic [2:0] COUNT_NONE   = 3'd0;
    localparam logic [2:0] COUNT_GUARD  = 3'd3;
    localparam logic [2:0] COUNT_CENTER = 3'd5;
    localparam logic [2:0] COUNT_DIGIT  = 3'd7;

    // Guard patterns, low aligned
    localparam logic [6:0] PAT_GUARD  = 7'b0000101;
    localparam logic [6:0] PAT_CENTER = 7'b0001010;

    typedef struct packed {
        logic [6:0] modules;
        logic [2:0] module_count;
        logic       last;
    } chunk_t;

    function automatic logic [6:0] code_left_odd(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0: c = 7'h0D;
            4'd1: c = 7'h19;
            4'd2: c = 7'h13;
            4'd3: c = 7'h3D;
            4'd4: c = 7'h23;
            4'd5: c = 7'h31;
            4'd6: c = 7'h2F;
            4'd7: c = 7'h3B;
            4'd8: c = 7'h37;
            4'd9: c = 7'h0B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] code_left_even(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0: c = 7'h27;
            4'd1: c = 7'h33;
            4'd2: c = 7'h1B;
            4'd3: c = 7'h21;
            4'd4: c = 7'h1D;
            4'd5: c = 7'h39;
            4'd6: c = 7'h05;
            4'd7: c = 7'h11;
            4'd8: c = 7'h09;
            4'd9: c = 7'h17;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] code_right(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0: c = 7'h72;
            4'd1: c = 7'h66;
            4'd2: c = 7'h6C;
            4'd3: c = 7'h42;
            4'd4: c = 7'h5C;
            4'd5: c = 7'h4E;
            4'd6: c = 7'h50;
            4'd7: c = 7'h44;
            4'd8: c = 7'h48;
            4'd9: c = 7'h74;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Bit 5 is the first left digit; 1 selects the G code
    function automatic logic [5:0] lead_parity(input logic [3:0] d);
        logic [5:0] p;
        case (d)
            4'd0: p = 6'h00;
            4'd1: p = 6'h0B;
            4'd2: p = 6'h0D;
            4'd3: p = 6'h0E;
            4'd4: p = 6'h13;
            4'd5: p = 6'h19;
            4'd6: p = 6'h1C;
            4'd7: p = 6'h15;
            4'd8: p = 6'h16;
            4'd9: p = 6'h1A;
            default: p = 6'h00;
        endcase
        return p;
    endfunction

    // Check digit from the weighted sum: reciprocal multiply for mod 10
    function automatic logic [3:0] check_from_sum(input wsum_t s);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        logic [3:0]  chk;
        prod = 16'(s) * 16'd205;
        quot = prod[15:11];
        rem  = s - (8'(quot) * 8'd10);
        chk  = (rem == 8'd0) ? 4'd0 : 4'(8'd10 - rem);
        return chk;
    endfunction

endpackage

`default_nettype wire

@@ design/ean13_barcode_encoder_core.sv @@
// The first chunk passes the input register, the sequencer and the result register on its
// way to the result ports; the fifteen chunks then follow one per cycle.
// One input can wait in the input register while the sequencer sends out the last one's chunks;
// a bad input gives a single error result and frees the sequencer with that result.
// busy rises only when the input register is full and the sequencer cannot take it.
// Reset clears all valid flags and the chunk counter; no result is given after reset.
`default_nettype none

module ean13_barcode_encoder_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [47:0] digits_bcd,
    output logic        result_valid,
    output logic [6:0]  modules,
    output logic [2:0]  module_count,
    output logic [3:0]  check_digit,
    output logic        bad_digit,
    output logic        last_chunk
);
    import ean13_pkg::*;

    // Input stage
    logic       in_valid_reg, in_valid_next;
    digit_vec_t in_digits_reg;
    wsum_t      in_sum_reg;
    logic       in_bad_reg;

    // Sequencer stage
    logic       work_valid_reg, work_valid_next;
    chunk_idx_t idx_reg, idx_next;
    digit_vec_t work_digits_reg;
    logic [3:0] work_chk_reg;
    logic       work_bad_reg;

    // Result register
    logic       result_valid_reg;
    logic [6:0] modules_reg;
    logic [2:0] module_count_reg;
    logic [3:0] check_digit_reg;
    logic       bad_digit_reg;
    logic       last_chunk_reg;

    wsum_t      csum;
    logic       cbad;
    chunk_t     chunk;
    logic       accept;
    logic       advance;
    logic       work_done;

    ean13_csum u_csum (
        .digits (digit_vec_t'(digits_bcd)),
        .wsum   (csum),
        .bad    (cbad)
    );

    ean13_chunk u_chunk (
        .idx    (idx_reg),
        .digits (work_digits_reg),
        .chk    (work_chk_reg),
        .bad    (work_bad_reg),
        .chunk  (chunk)
    );

    // Handshake and stage movement
    assign work_done = work_valid_reg && chunk.last;
    assign advance   = in_valid_reg && (!work_valid_reg || work_done);
    assign busy      = in_valid_reg && !advance;
    assign accept    = start && !busy;

    always_comb
    begin
        in_valid_next = accept || (in_valid_reg && !advance);
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        idx_next        = idx_reg;
        if (advance)
        begin
            work_valid_next = 1'b1;
            idx_next        = IDX_START;
        end
        else if (work_done)
        begin
            work_valid_next = 1'b0;
        end
        else if (work_valid_reg)
        begin
            idx_next = 4'(idx_reg + 4'd1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            work_valid_reg   <= 1'b0;
            idx_reg          <= IDX_START;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            work_valid_reg   <= work_valid_next;
            idx_reg          <= idx_next;
            result_valid_reg <= work_valid_reg;
        end
    end

    // Hold the accepted item with its weighted sum
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_digits_reg <= digit_vec_t'(digits_bcd);
            in_sum_reg    <= csum;
            in_bad_reg    <= cbad;
        end
    end

    // Load the sequencer and finish the check digit
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_digits_reg <= in_digits_reg;
            work_chk_reg    <= check_from_sum(in_sum_reg);
            work_bad_reg    <= in_bad_reg;
        end
    end

    // Register one chunk per cycle
    always_ff @(posedge clk)
    begin
        modules_reg      <= chunk.modules;
        module_count_reg <= chunk.module_count;
        check_digit_reg  <= work_bad_reg ? 4'd0 : work_chk_reg;
        bad_digit_reg    <= work_bad_reg;
        last_chunk_reg   <= chunk.last;
    end

    assign result_valid = result_valid_reg;
    assign modules      = modules_reg;
    assign module_count = module_count_reg;
    assign check_digit  = check_digit_reg;
    assign bad_digit    = bad_digit_reg;
    assign last_chunk   = last_chunk_reg;

endmodule

`default_nettype wire

@@ design/ean13_csum.sv @@
`default_nettype none

module ean13_csum (
    input  wire ean13_pkg::digit_vec_t digits,
    output ean13_pkg::wsum_t           wsum,
    output logic                       bad
);
    import ean13_pkg::*;

    logic [5:0][5:0] pair_sum;
    logic [DigitCount-1:0] over;

    // Pair each weight-1 digit with the following weight-3 digit
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pair_sum[k] = 6'(digits[11 - 2*k])
                        + 6'({digits[10 - 2*k], 1'b0})
                        + 6'(digits[10 - 2*k]);
        end
    end

    // Flag any nibble above nine
    always_comb
    begin
        for (int k = 0; k < DigitCount; k++)
        begin
            over[k] = (digits[k] > 4'd9);
        end
    end

    assign bad  = |over;
    assign wsum = (wsum_t'(pair_sum[0]) + wsum_t'(pair_sum[1]))
                + (wsum_t'(pair_sum[2]) + wsum_t'(pair_sum[3]))
                + (wsum_t'(pair_sum[4]) + wsum_t'(pair_sum[5]));

endmodule

`default_nettype wire

@@ design/ean13_chunk.sv @@
`default_nettype none

module ean13_chunk (
    input  wire ean13_pkg::chunk_idx_t idx,
    input  wire ean13_pkg::digit_vec_t digits,
    input  wire [3:0]                  chk,
    input  wire                        bad,
    output ean13_pkg::chunk_t          chunk
);
    import ean13_pkg::*;

    logic [3:0] pos;
    logic [3:0] digit;
    logic [5:0] parity;
    logic       use_g;

    // Select the digit for this chunk; right half skips the center guard
    assign pos    = (idx <= IDX_LEFT_LAST) ? idx : 4'(idx - 4'd1);
    assign digit  = digits[4'(4'd11 - pos)];
    assign parity = lead_parity(digits[DigitCount-1]);
    assign use_g  = parity[3'(4'd6 - idx)];

    always_comb
    begin
        chunk.modules      = 7'd0;
        chunk.module_count = COUNT_NONE;
        chunk.last         = 1'b0;
        if (bad)
        begin
            chunk.last = 1'b1;
        end
        else
        begin
            case (idx)
                IDX_START:
                begin
                    chunk.modules      = PAT_GUARD;
                    chunk.module_count = COUNT_GUARD;
                end
                IDX_CENTER:
                begin
                    chunk.modules      = PAT_CENTER;
                    chunk.module_count = COUNT_CENTER;
                end
                IDX_CHECK:
                begin
                    chunk.modules      = code_right(chk);
                    chunk.module_count = COUNT_DIGIT;
                end
                IDX_END:
                begin
                    chunk.modules      = PAT_GUARD;
                    chunk.module_count = COUNT_GUARD;
                    chunk.last         = 1'b1;
                end
                default:
                begin
                    chunk.module_count = COUNT_DIGIT;
                    if (idx < IDX_CENTER)
                    begin
                        chunk.modules = use_g ? code_left_even(digit) : code_left_odd(digit);
                    end
                    else
                    begin
                        chunk.modules = code_right(digit);
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/ean13_checker.sv @@
`default_nettype none

module ean13_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       result_valid,
    input wire [2:0] module_count,
    input wire [3:0] check_digit,
    input wire       bad_digit,
    input wire       last_chunk
);
    import ean13_pkg::*;

    // Error result stands alone and carries no pattern
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_digit |-> last_chunk && module_count == COUNT_NONE)
        else $error("error result not a single empty chunk");

    // A run continues without gaps until its last chunk
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_chunk |=> result_valid)
        else $error("gap inside a chunk run");

    // Check digit is constant over a run
    a_chk_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_chunk |=> $stable(check_digit))
        else $error("check digit changed within a run");

    // Pattern chunks have a legal width and a decimal check digit
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !bad_digit |-> check_digit <= 4'd9 &&
        (module_count == COUNT_GUARD || module_count == COUNT_CENTER ||
         module_count == COUNT_DIGIT))
        else $error("illegal chunk width or check digit");

endmodule

bind ean13_barcode_encoder_core ean13_checker u_ean13_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .module_count (module_count),
    .check_digit  (check_digit),
    .bad_digit    (bad_digit),
    .last_chunk   (last_chunk)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import ean13_pkg::*;

    // One expected bar chunk as it should appear on the result ports
    typedef struct packed {
        logic [6:0] modules;
        logic [2:0] module_count;
        logic [3:0] check_digit;
        logic       bad_digit;
        logic       last_chunk;
    } bar_chunk_t;

    // One digit word waiting to be sent, with its lead-in gap
    typedef struct {
        logic [47:0] digits;
        int unsigned gap;
        bit          drain;
    } digit_word_t;

    // L code of digits 0..9, digit 0 in the low bits; R is its inverse, G the mirror of R
    localparam logic [69:0] L_CODES = {7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31,
                                       7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
    // G-code selection per first digit, bit 5 for the first left digit
    localparam logic [59:0] PARITY_SEL = {6'h1A, 6'h16, 6'h15, 6'h1C, 6'h19,
                                          6'h13, 6'h0E, 6'h0D, 6'h0B, 6'h00};
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_WORDS = 460;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [47:0] digits_bcd = '0;
    logic        busy;
    logic        result_valid;
    logic [6:0]  modules;
    logic [2:0]  module_count;
    logic [3:0]  check_digit;
    logic        bad_digit;
    logic        last_chunk;

    digit_word_t word_q[$];
    bar_chunk_t  expected_chunks[$];

    int unsigned words_raised = 0;
    int unsigned words_taken = 0;
    int unsigned bad_words = 0;
    int unsigned chunks_checked = 0;
    int unsigned drain_pauses = 0;
    int unsigned mismatches = 0;
    int unsigned gap_count = 0;

    ean13_barcode_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .digits_bcd   (digits_bcd),
        .result_valid (result_valid),
        .modules      (modules),
        .module_count (module_count),
        .check_digit  (check_digit),
        .bad_digit    (bad_digit),
        .last_chunk   (last_chunk)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Count a failure, print the first few
    task automatic note_failure(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Build the expected chunk run of one digit word
    task automatic encode_ean13(input logic [47:0] word);
        logic [3:0] d[12];
        logic [5:0] sel;
        logic [6:0] l_code;
        logic [6:0] r_code;
        logic [6:0] g_code;
        logic [3:0] chk;
        int unsigned sum;
        bit bad;
        bad = 1'b0;
        sum = 0;
        for (int i = 0; i < 12; i++)
        begin
            d[i] = word[47 - 4 * i -: 4];
            if (d[i] > 4'd9)
                bad = 1'b1;
        end
        if (bad)
        begin
            bad_words++;
            expected_chunks.push_back('{7'd0, COUNT_NONE, 4'd0, 1'b1, 1'b1});
            return;
        end
        for (int i = 0; i < 12; i++)
            sum += (i % 2 == 1) ? 3 * d[i] : d[i];
        chk = 4'((10 - sum % 10) % 10);

        expected_chunks.push_back('{PAT_GUARD, COUNT_GUARD, chk, 1'b0, 1'b0});
        // Left half: L or G per parity of the first digit
        sel = PARITY_SEL[d[0] * 6 +: 6];
        for (int i = 0; i < 6; i++)
        begin
            l_code = L_CODES[d[i + 1] * 7 +: 7];
            r_code = ~l_code;
            for (int b = 0; b < 7; b++)
                g_code[b] = r_code[6 - b];
            expected_chunks.push_back('{sel[5 - i] ? g_code : l_code, COUNT_DIGIT, chk,
                                        1'b0, 1'b0});
        end
        expected_chunks.push_back('{PAT_CENTER, COUNT_CENTER, chk, 1'b0, 1'b0});
        // Right half in R code, ending with the check digit
        for (int i = 7; i < 13; i++)
        begin
            l_code = L_CODES[((i < 12) ? d[i] : chk) * 7 +: 7];
            expected_chunks.push_back('{~l_code, COUNT_DIGIT, chk, 1'b0, 1'b0});
        end
        expected_chunks.push_back('{PAT_GUARD, COUNT_GUARD, chk, 1'b0, 1'b1});
    endtask

    function automatic logic [47:0] random_digits(input int first);
        logic [47:0] w;
        w[47:44] = (first < 0) ? 4'($urandom_range(0, 9)) : 4'(first);
        for (int i = 1; i < 12; i++)
            w[47 - 4 * i -: 4] = 4'($urandom_range(0, 9));
        return w;
    endfunction

    function automatic logic [47:0] corrupt_nibble(input logic [47:0] w);
        logic [47:0] c;
        int unsigned pos;
        c = w;
        pos = $urandom_range(0, 11);
        c[4 * pos +: 4] = 4'($urandom_range(10, 15));
        return c;
    endfunction

    task automatic queue_word(input logic [47:0] w, input int unsigned gap, input bit drain);
        word_q.push_back('{w, gap, drain});
    endtask

    // Driver: present words on the falling edge, hold start until the transfer
    always @(negedge clk)
    begin : drive_words
        logic        next_start;
        logic [47:0] next_word;
        digit_word_t item;
        next_start = 1'b0;
        next_word = {16'($urandom), 32'($urandom)};
        if (!rst_n)
            next_word = '0;
        else if (start && words_taken != words_raised)
        begin
            next_start = 1'b1;
            next_word = digits_bcd;
        end
        else if (word_q.size() != 0)
        begin
            if (gap_count < word_q[0].gap)
                gap_count++;
            else if (word_q[0].drain && expected_chunks.size() != 0)
                gap_count = gap_count;
            else
            begin
                item = word_q.pop_front();
                if (item.drain)
                    drain_pauses++;
                next_start = 1'b1;
                next_word = item.digits;
                words_raised++;
                gap_count = 0;
            end
        end
        start <= next_start;
        digits_bcd <= next_word;
    end

    // Monitor: check each strobed chunk, then predict for a fresh transfer
    always @(posedge clk)
    begin : check_chunks
        bar_chunk_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                chunks_checked++;
                if (expected_chunks.size() == 0)
                    note_failure($sformatf("unexpected chunk modules=%h count=%0d chk=%0d bad=%b last=%b",
                                           modules, module_count, check_digit, bad_digit,
                                           last_chunk));
                else
                begin
                    want = expected_chunks.pop_front();
                    if (modules !== want.modules || module_count !== want.module_count ||
                        check_digit !== want.check_digit || bad_digit !== want.bad_digit ||
                        last_chunk !== want.last_chunk)
                        note_failure($sformatf({"expected modules=%h count=%0d chk=%0d bad=%b last=%b",
                                                " got modules=%h count=%0d chk=%0d bad=%b last=%b"},
                                               want.modules, want.module_count, want.check_digit,
                                               want.bad_digit, want.last_chunk, modules,
                                               module_count, check_digit, bad_digit, last_chunk));
                end
            end
            if (start && !busy)
            begin
                encode_ean13(digits_bcd);
                words_taken++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : run_test
        logic [47:0] w;
        int unsigned pick;
        int unsigned gap;
        int unsigned wait_cycles;

        // Directed: extremes, every first digit, bad nibbles at the edges and in the middle
        queue_word(48'h0000_0000_0000, 0, 1'b0);
        queue_word(48'h9999_9999_9999, 0, 1'b0);
        for (int f = 0; f < 10; f++)
            queue_word(random_digits(f), f % 3, 1'b0);
        queue_word(48'h4006_3813_3931, 0, 1'b0);
        queue_word(48'hF000_0000_0000, 0, 1'b0);
        queue_word(48'h0000_0000_000A, 0, 1'b0);
        queue_word(48'h1234_5B78_9012, 1, 1'b0);
        queue_word(48'hFFFF_FFFF_FFFF, 0, 1'b0);
        queue_word(48'h9999_9999_999C, 0, 1'b0);
        queue_word(random_digits(-1), 0, 1'b1);

        // Random: mostly valid words, some corrupted; a no-gap stretch in the middle
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                w = random_digits(-1);
            else if (pick < 95)
                w = corrupt_nibble(random_digits(-1));
            else
                w = {16'($urandom), 32'($urandom)};
            gap = (i >= 150 && i < 300) ? 0 : $urandom_range(0, 4);
            queue_word(w, gap, i == 200 || i == 350 || $urandom_range(0, 59) == 0);
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Let every word transfer, then drain the expected chunks
        while (word_q.size() != 0 || words_taken != words_raised)
            @(posedge clk);
        wait_cycles = 0;
        while (expected_chunks.size() != 0 && wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (expected_chunks.size() != 0)
        begin
            want_missing : begin
                bar_chunk_t left;
                left = expected_chunks.pop_front();
                note_failure($sformatf("missing chunk modules=%h count=%0d last=%b",
                                       left.modules, left.module_count, left.last_chunk));
            end
        end

        $display("Run covered %0d digit words (%0d with a bad nibble) and %0d chunks checked,",
                 words_taken, bad_words, chunks_checked);
        $display("with %0d drain pauses and %0d mismatches.", drain_pauses, mismatches);
        if (mismatches == 0)
            $display("ean13_barcode_encoder_core verification clean");
        else
            $display("ean13_barcode_encoder_core verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #500000;
        $display("Timeout at %0t", $realtime);
        $display("ean13_barcode_encoder_core verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ean13_pkg.sv
design/ean13_csum.sv
design/ean13_chunk.sv
design/ean13_barcode_encoder_core.sv
design/ean13_checker.sv
tb/testbench.sv
